[src/cms_pkg.sv]
// Shared types and codes for the counting multiset table.
// Used by cms_ctrl, cms_datapath and counting_multiset_table; no dependencies.
package cms_pkg;

   localparam int ENTRIES_DEFAULT    = 16;
   localparam int COUNT_BITS_DEFAULT = 16;

   localparam int MULT_BITS  = 16;
   localparam int TOTAL_BITS = 20;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;
   localparam logic [1:0] CMD_TOTAL  = 2'd3;

   localparam logic [1:0] STS_OK     = 2'd0;
   localparam logic [1:0] STS_FULL   = 2'd1;
   localparam logic [1:0] STS_ABSENT = 2'd2;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] item_value;
   } req_payload_type;

   typedef struct packed {
      logic [MULT_BITS-1:0]  multiplicity;
      logic [TOTAL_BITS-1:0] total_count;
      logic [1:0]            status;
   } rsp_payload_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } ctrl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_item;
      logic execute;
      logic pending;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

[src/cms_ctrl.sv]
// Sequencer for the counting multiset table: holds one item at a time and
// fires the datapath once the result register can take a new beat.
// Depends on cms_pkg.
module cms_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  cms_pkg::dp_status_type dp_status,
   output cms_pkg::ctrl_cmd_type  dp_cmd
);

   cms_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cms_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in          = state_ff;
      req_ready         = 1'b0;
      dp_cmd.load_item  = 1'b0;
      dp_cmd.execute    = 1'b0;
      dp_cmd.pending    = 1'b0;
      case (state_ff)
         cms_pkg::ST_IDLE: begin
            req_ready        = 1'b1;
            dp_cmd.load_item = req_valid;
            if (req_valid) begin
               state_in = cms_pkg::ST_EXEC;
            end
         end
         cms_pkg::ST_EXEC: begin
            dp_cmd.pending = 1'b1;
            // the held item retires as the next one comes in
            if (dp_status.out_free) begin
               dp_cmd.execute   = 1'b1;
               req_ready        = 1'b1;
               dp_cmd.load_item = req_valid;
               state_in         = req_valid ? cms_pkg::ST_EXEC : cms_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cms_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[src/cms_datapath.sv]
// Datapath of the counting multiset table: item register, slot array with
// parallel match, running total and result register. Depends on cms_pkg.
module cms_datapath #(
   parameter int ENTRIES    = cms_pkg::ENTRIES_DEFAULT,
   parameter int COUNT_BITS = cms_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cms_pkg::req_payload_type req_payload,
   input  cms_pkg::ctrl_cmd_type    dp_cmd,
   output cms_pkg::dp_status_type   dp_status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output cms_pkg::rsp_payload_type rsp_payload
);

   localparam int SUM_BITS = COUNT_BITS + $clog2(ENTRIES) + 1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS+cms_pkg::MULT_BITS-1:0] MULT_LIMIT =
      {{COUNT_BITS{1'b0}}, {cms_pkg::MULT_BITS{1'b1}}};
   localparam logic [SUM_BITS+cms_pkg::TOTAL_BITS-1:0] TOTAL_LIMIT =
      {{SUM_BITS{1'b0}}, {cms_pkg::TOTAL_BITS{1'b1}}};

   cms_pkg::req_payload_type item_ff;
   logic signed [31:0]       value_ff [ENTRIES];
   logic [COUNT_BITS-1:0]    count_ff [ENTRIES];
   logic [COUNT_BITS-1:0]    count_in [ENTRIES];
   logic [ENTRIES-1:0]       valid_ff, valid_in;
   logic [SUM_BITS-1:0]      sum_ff, sum_in;
   cms_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic                     rsp_valid_ff;

   logic [ENTRIES-1:0]       hit;
   logic [ENTRIES-1:0]       free_oh;
   logic                     any_hit, any_free;
   logic [COUNT_BITS-1:0]    match_cnt, new_cnt, mult;
   logic [1:0]               status;
   logic                     take_free;
   logic [COUNT_BITS+cms_pkg::MULT_BITS-1:0] mult_ext;
   logic [SUM_BITS+cms_pkg::TOTAL_BITS-1:0]  sum_ext;

   assign dp_status.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (dp_cmd.load_item) begin
         item_ff <= req_payload;
      end
   end

   // stored values are unique among valid slots, so at most one hit
   always_comb begin
      match_cnt = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit[i] = valid_ff[i] && (value_ff[i] == item_ff.item_value);
         if (hit[i]) begin
            match_cnt = match_cnt | count_ff[i];
         end
      end
      any_hit  = |hit;
      any_free = !(&valid_ff);
      // isolate lowest clear bit
      free_oh  = ~valid_ff & (valid_ff + {{(ENTRIES-1){1'b0}}, 1'b1});
   end

   always_comb begin
      new_cnt   = match_cnt;
      mult      = '0;
      status    = cms_pkg::STS_OK;
      sum_in    = sum_ff;
      take_free = 1'b0;
      case (item_ff.command)
         cms_pkg::CMD_ADD: begin
            if (any_hit) begin
               if (match_cnt != COUNT_MAX) begin
                  new_cnt = match_cnt + 1'b1;
                  sum_in  = sum_ff + 1'b1;
               end
               mult = new_cnt;
            end else if (any_free) begin
               take_free = 1'b1;
               mult      = {{(COUNT_BITS-1){1'b0}}, 1'b1};
               sum_in    = sum_ff + 1'b1;
            end else begin
               status = cms_pkg::STS_FULL;
            end
         end
         cms_pkg::CMD_REMOVE: begin
            if (any_hit) begin
               new_cnt = match_cnt - 1'b1;
               mult    = new_cnt;
               sum_in  = sum_ff - 1'b1;
            end else begin
               status = cms_pkg::STS_ABSENT;
            end
         end
         cms_pkg::CMD_QUERY: begin
            mult = match_cnt;
         end
         cms_pkg::CMD_TOTAL: begin
            mult = '0;
         end
         default: begin
            mult = '0;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         count_in[i] = count_ff[i];
         valid_in[i] = valid_ff[i];
         if (hit[i] && (item_ff.command == cms_pkg::CMD_ADD ||
                        item_ff.command == cms_pkg::CMD_REMOVE)) begin
            count_in[i] = new_cnt;
            valid_in[i] = new_cnt != '0;
         end else if (take_free && free_oh[i]) begin
            count_in[i] = {{(COUNT_BITS-1){1'b0}}, 1'b1};
            valid_in[i] = 1'b1;
         end
      end
   end

   always_comb begin
      mult_ext = {{cms_pkg::MULT_BITS{1'b0}}, mult};
      sum_ext  = {{cms_pkg::TOTAL_BITS{1'b0}}, sum_in};
      rsp_in.multiplicity = (mult_ext > MULT_LIMIT) ? {cms_pkg::MULT_BITS{1'b1}}
                                                    : mult_ext[cms_pkg::MULT_BITS-1:0];
      rsp_in.total_count  = (sum_ext > TOTAL_LIMIT) ? {cms_pkg::TOTAL_BITS{1'b1}}
                                                    : sum_ext[cms_pkg::TOTAL_BITS-1:0];
      rsp_in.status       = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         sum_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            count_ff[i] <= '0;
         end
      end else if (dp_cmd.execute) begin
         valid_ff <= valid_in;
         sum_ff   <= sum_in;
         for (int i = 0; i < ENTRIES; i++) begin
            count_ff[i] <= count_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (dp_cmd.execute && take_free && free_oh[i]) begin
            value_ff[i] <= item_ff.item_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.execute) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

[src/counting_multiset_table.sv]
// Counting multiset table: bounded set of Q16.16 values with multiplicities.
// req_ beats carry a command (add, remove, query, total) and a value; each
// beat yields exactly one rsp_ beat with multiplicity, total and status.
// Values match on exact bit pattern; new values take the lowest free slot.
// An accepted request is held in the item register, then executed into the result register that drives rsp_.
// Throughput: one beat per cycle while rsp_ready stays high; the limit is
// the single held item in the execute stage, which retires only when the
// result register is empty or drained in the same cycle.
// A stalled rsp_ holds its beat; one more request is taken and waits in
// the execute stage, after which req_ready drops until rsp_ready returns.
// Reset (synchronous, active high) empties every slot and clears the
// total; no request is lost or duplicated across a stall.
// Counts saturate at 2^COUNT_BITS-1; reported fields saturate to width.
// Depends on cms_pkg, cms_ctrl and cms_datapath.
module counting_multiset_table #(
   parameter int ENTRIES    = cms_pkg::ENTRIES_DEFAULT,
   parameter int COUNT_BITS = cms_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  cms_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output cms_pkg::rsp_payload_type rsp_payload
);

   cms_pkg::ctrl_cmd_type  dp_cmd;
   cms_pkg::dp_status_type dp_status;

   cms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   cms_datapath #(
      .ENTRIES    (ENTRIES),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // an accepted request is always held for execution next cycle
   a_accept_holds: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> dp_cmd.pending)
      else $error("accepted request not held");

   // execution always lands a result beat
   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.execute |=> rsp_valid)
      else $error("execute did not produce a result");

   // never execute without a held item
   a_exec_pending: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.execute |-> dp_cmd.pending)
      else $error("execute with no item held");

   // a blocked result stage must stall the request side when busy
   a_stall_backpressure: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.pending && !dp_status.out_free) |-> !req_ready)
      else $error("request taken while result stage blocked");

endmodule

[verif/counting_multiset_table_test.sv]
// Self-checking testbench for counting_multiset_table: directed and random beats,
// with a scoreboard class that predicts each result and compares it field by field.
// Depends on cms_pkg and the counting_multiset_table RTL.
`timescale 1ns / 100ps

module counting_multiset_table_test;

   localparam int TB_ENTRIES    = cms_pkg::ENTRIES_DEFAULT;
   localparam int TB_COUNT_BITS = cms_pkg::COUNT_BITS_DEFAULT;
   localparam int RANDOM_ITEMS  = 1620;
   localparam longint unsigned COUNT_CAP = (64'd1 << TB_COUNT_BITS) - 1;
   localparam longint unsigned MULT_CAP  = (64'd1 << cms_pkg::MULT_BITS) - 1;
   localparam longint unsigned TOTAL_CAP = (64'd1 << cms_pkg::TOTAL_BITS) - 1;

   class multiset_scoreboard;
      logic [31:0]               slot_value[TB_ENTRIES];
      longint unsigned           slot_count[TB_ENTRIES];
      bit                        slot_used[TB_ENTRIES];
      longint unsigned           total_sum;
      cms_pkg::rsp_payload_type  expected_q[$];
      int unsigned               fail_count;

      function new();
         for (int i = 0; i < TB_ENTRIES; i++) begin
            slot_value[i] = '0;
            slot_count[i] = 0;
            slot_used[i]  = 1'b0;
         end
         total_sum  = 0;
         fail_count = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Update the shadow multiset for one accepted request beat.
      function void note_request(cms_pkg::req_payload_type r);
         int                       hit;
         int                       spare;
         longint unsigned          mult_raw;
         cms_pkg::rsp_payload_type e;
         hit      = -1;
         spare    = -1;
         mult_raw = 0;
         e        = '0;
         e.status = cms_pkg::STS_OK;
         for (int i = 0; i < TB_ENTRIES; i++) begin
            if (hit < 0 && slot_used[i] && slot_value[i] == r.item_value) hit = i;
            if (spare < 0 && !slot_used[i]) spare = i;
         end
         case (r.command)
            cms_pkg::CMD_ADD: begin
               if (hit >= 0) begin
                  if (slot_count[hit] < COUNT_CAP) begin
                     slot_count[hit]++;
                     total_sum++;
                  end
                  mult_raw = slot_count[hit];
               end else if (spare >= 0) begin
                  slot_used[spare]  = 1'b1;
                  slot_value[spare] = r.item_value;
                  slot_count[spare] = 1;
                  total_sum++;
                  mult_raw = 1;
               end else begin
                  e.status = cms_pkg::STS_FULL;
               end
            end
            cms_pkg::CMD_REMOVE: begin
               if (hit >= 0) begin
                  if (slot_count[hit] > 1) begin
                     slot_count[hit]--;
                     mult_raw = slot_count[hit];
                  end else begin
                     slot_count[hit] = 0;
                     slot_used[hit]  = 1'b0;
                  end
                  if (total_sum != 0) total_sum--;
               end else begin
                  e.status = cms_pkg::STS_ABSENT;
               end
            end
            cms_pkg::CMD_QUERY: begin
               if (hit >= 0) mult_raw = slot_count[hit];
            end
            default: ;
         endcase
         e.multiplicity = (mult_raw > MULT_CAP) ? MULT_CAP[cms_pkg::MULT_BITS-1:0]
                                                : mult_raw[cms_pkg::MULT_BITS-1:0];
         e.total_count  = (total_sum > TOTAL_CAP) ? TOTAL_CAP[cms_pkg::TOTAL_BITS-1:0]
                                                  : total_sum[cms_pkg::TOTAL_BITS-1:0];
         expected_q.push_back(e);
      endfunction

      function void check_result(cms_pkg::rsp_payload_type got);
         cms_pkg::rsp_payload_type want;
         if (expected_q.size() == 0) begin
            $error("result beat with nothing outstanding: mult %0d total %0d status %0d",
                   got.multiplicity, got.total_count, got.status);
            fail_count++;
            return;
         end
         want = expected_q.pop_front();
         if (got.multiplicity !== want.multiplicity) begin
            $error("multiplicity: expected %0d, actual %0d", want.multiplicity,
                   got.multiplicity);
            fail_count++;
         end
         if (got.total_count !== want.total_count) begin
            $error("total_count: expected %0d, actual %0d", want.total_count,
                   got.total_count);
            fail_count++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_count++;
         end
      endfunction
   endclass

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_ready;
   cms_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_ready   = 1'b0;
   cms_pkg::rsp_payload_type rsp_payload;

   multiset_scoreboard sb;

   counting_multiset_table #(
      .ENTRIES    (TB_ENTRIES),
      .COUNT_BITS (TB_COUNT_BITS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_payload);
   end

   // Result side: random stall before each beat.
   initial begin : rsp_side
      int unsigned stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = $urandom_range(0, 3);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_command(input logic [1:0] cmd, input logic [31:0] value);
      int unsigned              gap;
      cms_pkg::req_payload_type p;
      gap          = $urandom_range(0, 3);
      p.command    = cmd;
      p.item_value = value;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      sb.note_request(p);
   endtask

   initial begin : stimulus
      logic [31:0] pool[$];
      logic [31:0] value;
      logic [1:0]  cmd;
      int unsigned roll;
      bit          add_heavy;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table: total, query and remove of an absent value.
      send_command(cms_pkg::CMD_TOTAL, $urandom);
      send_command(cms_pkg::CMD_QUERY, 32'h0000_0000);
      send_command(cms_pkg::CMD_REMOVE, 32'h0000_0000);
      send_command(cms_pkg::CMD_ADD, 32'h8000_0000);
      send_command(cms_pkg::CMD_ADD, 32'h7FFF_FFFF);
      send_command(cms_pkg::CMD_ADD, 32'h0000_0000);
      send_command(cms_pkg::CMD_ADD, 32'h0000_0000);
      send_command(cms_pkg::CMD_QUERY, 32'h0000_0000);
      send_command(cms_pkg::CMD_REMOVE, 32'h0000_0000);
      send_command(cms_pkg::CMD_REMOVE, 32'h0000_0000);   // count hits zero, slot freed
      send_command(cms_pkg::CMD_QUERY, 32'h0000_0000);
      send_command(cms_pkg::CMD_ADD, 32'hFFFF_FFFF);      // reuses the lowest free slot
      for (int k = 1; k <= 13; k++) send_command(cms_pkg::CMD_ADD, 32'(k) << 16);
      send_command(cms_pkg::CMD_ADD, 32'h0001_8000);      // no slot left
      send_command(cms_pkg::CMD_ADD, 32'h7FFF_FFFF);      // existing value still counts up
      send_command(cms_pkg::CMD_REMOVE, 32'h8000_0000);
      send_command(cms_pkg::CMD_ADD, 32'h0001_8000);
      send_command(cms_pkg::CMD_TOTAL, 32'hFFFF_FFFF);

      pool.push_back(32'h8000_0000);
      pool.push_back(32'h7FFF_FFFF);
      pool.push_back(32'hFFFF_FFFF);
      pool.push_back(32'h0000_0000);
      pool.push_back(32'h0001_8000);
      for (int k = 1; k <= 13; k++) pool.push_back(32'(k) << 16);
      for (int k = 0; k < 7; k++) pool.push_back($urandom);

      // Alternate fill-up and drain-down phases so full and empty both recur.
      add_heavy = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) begin
            add_heavy = ((n / 150) % 2) == 0;
         end
         roll = $urandom_range(0, 99);
         if (add_heavy)
            cmd = (roll < 55) ? cms_pkg::CMD_ADD : (roll < 75) ? cms_pkg::CMD_REMOVE :
                  (roll < 92) ? cms_pkg::CMD_QUERY : cms_pkg::CMD_TOTAL;
         else
            cmd = (roll < 20) ? cms_pkg::CMD_ADD : (roll < 65) ? cms_pkg::CMD_REMOVE :
                  (roll < 90) ? cms_pkg::CMD_QUERY : cms_pkg::CMD_TOTAL;
         if ($urandom_range(0, 9) == 0) value = $urandom;
         else value = pool[$urandom_range(0, pool.size() - 1)];
         send_command(cmd, value);
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.fail_count == 0)
         $display("** counting_multiset_table: PASSED **");
      else
         $display("** counting_multiset_table: FAILED **");
      $finish;
   end

   initial begin : watchdog
      #30_000_000;
      $display("** counting_multiset_table: FAILED **");
      $finish;
   end

endmodule
